@@ rtl/msr_pkg.sv @@
package msr_pkg;

  localparam int MAX_ROWS    = 64;
  localparam int MAX_COLS    = 64;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

  localparam int ELEM_W    = 32;
  localparam int SUM_W     = 44;
  localparam int DIM_W     = 7;
  localparam int ADDR_W    = $clog2(STORE_DEPTH);
  localparam int POS_W     = ADDR_W + 1;
  localparam int ROW_IDX_W = $clog2(MAX_ROWS);
  localparam int COL_IDX_W = $clog2(MAX_COLS);

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic signed [SUM_W-1:0] MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic [ADDR_W-1:0]        addr;
    logic                     last;
  } q_entry_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_SCAN,
    B_DRAIN,
    B_OUT
  } back_state_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/max_sum_subrectangle_top.sv @@
// Largest sum over all non-empty subrectangles of a signed matrix.
// Input channel: one 32-bit element per beat in row-major order, rows of
// col_count elements, row_count rows (both set through the APB port at
// addresses 0 and 4, low 7 bits kept, 0 or above 64 clamped when used).
// Output channel: one 44-bit max_sum beat per complete matrix.
// Elements enter a 4-entry queue at up to one per cycle and are written to
// the matrix memory one per cycle while loading. After the last element the
// search walks every left/right column pair, one row per cycle through a
// shared adder and scan pipeline; no element enters the memory until the
// search is done and its result has been taken into the output register.
// While the search runs the queue fills and in_stall rises.
// Reset: dimensions return to 64x64, load position and queue clear, no
// result pending. The matrix memory is not cleared.
// A stalled result holds in the output register; the next matrix still
// loads and is searched, then its result waits and the queue fills up.
module max_sum_subrectangle_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [msr_pkg::ELEM_W-1:0]     in_element,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [msr_pkg::SUM_W-1:0]      out_max_sum,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [msr_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [msr_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [msr_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);
  import msr_pkg::*;

  logic [DIM_W-1:0] row_count_r, col_count_r;
  logic [DIM_W-1:0] rows, cols;
  logic             cfg_wr;
  q_entry_t         q_wdata, q_rdata;
  logic             q_push, q_pop, q_empty, q_full;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= DIM_W'(64);
      col_count_r <= DIM_W'(64);
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_ROW_COUNT: row_count_r <= cfg_pwdata[DIM_W-1:0];
        REG_COL_COUNT: col_count_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_ROW_COUNT: cfg_prdata = CFG_DATA_W'(row_count_r);
      REG_COL_COUNT: cfg_prdata = CFG_DATA_W'(col_count_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign rows = clamp_dim(row_count_r, DIM_W'(MAX_ROWS));
  assign cols = clamp_dim(col_count_r, DIM_W'(MAX_COLS));

  msr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_element (in_element),
    .rows       (rows),
    .cols       (cols),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  msr_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  msr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (!q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .rows        (rows),
    .cols        (cols),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_max_sum (out_max_sum)
  );

endmodule

@@ rtl/msr_fifo.sv @@
module msr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  msr_pkg::q_entry_t wdata,
  input  logic              pop,
  output msr_pkg::q_entry_t rdata,
  output logic              empty,
  output logic              full
);
  import msr_pkg::*;

  q_entry_t             slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == Q_CNT_W'(Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/msr_front.sv @@
module msr_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [msr_pkg::ELEM_W-1:0] in_element,
  input  logic [msr_pkg::DIM_W-1:0]        rows,
  input  logic [msr_pkg::DIM_W-1:0]        cols,
  input  logic                             q_full,
  output logic                             q_push,
  output msr_pkg::q_entry_t                q_wdata
);
  import msr_pkg::*;

  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]     pos_inc;
  logic [2*DIM_W-1:0]   total;
  logic                 last;
  logic                 accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign total    = rows * cols;
  assign pos_inc  = {1'b0, pos_r} + 1'b1;
  // matrix is complete once the position reaches rows*cols under current dims
  assign last     = ((2*DIM_W)'(pos_inc) >= total);

  assign q_push          = accept;
  assign q_wdata.element = in_element;
  assign q_wdata.addr    = pos_r;
  assign q_wdata.last    = last;

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      pos_nxt = last ? '0 : pos_inc[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

@@ rtl/msr_back.sv @@
module msr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  msr_pkg::q_entry_t                 q_data,
  output logic                              q_pop,
  input  logic [msr_pkg::DIM_W-1:0]         rows,
  input  logic [msr_pkg::DIM_W-1:0]         cols,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [msr_pkg::SUM_W-1:0]  out_max_sum
);
  import msr_pkg::*;

  logic signed [ELEM_W-1:0] matrix_store_r [STORE_DEPTH];
  logic signed [SUM_W-1:0]  strip_sums_r   [MAX_ROWS];

  back_state_t              state_r, state_nxt;
  logic [COL_IDX_W-1:0]     left_r, left_nxt;
  logic [COL_IDX_W-1:0]     right_r, right_nxt;
  logic [ROW_IDX_W-1:0]     row_r, row_nxt;
  logic [ADDR_W-1:0]        base_r, base_nxt;
  logic                     issue, start, load_out;
  logic [DIM_W-1:0]         rows_m1, cols_m1;

  // stage 1: memory read data
  logic                     s1_vld_r, s1_first_col_r, s1_first_row_r, s1_last_row_r;
  logic [ROW_IDX_W-1:0]     s1_row_r;
  logic signed [ELEM_W-1:0] mat_q_r;
  logic signed [SUM_W-1:0]  strip_q_r;
  logic                     fwd_r, fwd_nxt;
  logic signed [SUM_W-1:0]  fwd_data_r;
  logic signed [SUM_W-1:0]  s1_old, s1_sum;

  // stage 2: kadane over the strip's row sums
  logic                     s2_vld_r, s2_first_row_r, s2_last_row_r;
  logic signed [SUM_W-1:0]  s2_sum_r;
  logic signed [SUM_W-1:0]  run_r, top_r, maxv_r;
  logic                     seen_r;
  logic signed [SUM_W-1:0]  run_base, top_base, run_sum, run_new, top_new, maxv_new;
  logic                     seen_new;
  logic signed [SUM_W-1:0]  strip_res;

  // stage 3: best over strips
  logic                     s3_vld_r;
  logic signed [SUM_W-1:0]  s3_res_r;
  logic signed [SUM_W-1:0]  best_r;

  logic                     out_valid_r;
  logic signed [SUM_W-1:0]  out_max_sum_r;

  assign rows_m1     = rows - 1'b1;
  assign cols_m1     = cols - 1'b1;
  assign out_valid   = out_valid_r;
  assign out_max_sum = out_max_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    row_nxt   = row_r;
    base_nxt  = base_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    start     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      B_LOAD: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.last) begin
            state_nxt = B_SCAN;
            start     = 1'b1;
            left_nxt  = '0;
            right_nxt = '0;
            row_nxt   = '0;
            base_nxt  = '0;
          end
        end
      end
      B_SCAN: begin
        issue = 1'b1;
        if (DIM_W'(row_r) == rows_m1) begin
          row_nxt = '0;
          if (DIM_W'(right_r) == cols_m1) begin
            if (DIM_W'(left_r) == cols_m1) begin
              state_nxt = B_DRAIN;
            end else begin
              left_nxt  = left_r + 1'b1;
              right_nxt = left_r + 1'b1;
              base_nxt  = ADDR_W'(left_r) + 1'b1;
            end
          end else begin
            right_nxt = right_r + 1'b1;
            base_nxt  = ADDR_W'(right_r) + 1'b1;
          end
        end else begin
          row_nxt  = row_r + 1'b1;
          base_nxt = base_r + ADDR_W'(cols);
        end
      end
      B_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r && !s3_vld_r) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = B_LOAD;
        end
      end
      default: begin
        state_nxt = B_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    left_r  <= left_nxt;
    right_r <= right_nxt;
    row_r   <= row_nxt;
    base_r  <= base_nxt;
  end

  // memories
  always_ff @(posedge clk) begin
    if (q_pop) begin
      matrix_store_r[q_data.addr] <= q_data.element;
    end
    if (issue) begin
      mat_q_r   <= matrix_store_r[base_r];
      strip_q_r <= strip_sums_r[row_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      strip_sums_r[s1_row_r] <= s1_sum;
    end
  end

  // single-row strips read the row sum at the edge it is written
  assign fwd_nxt = issue && s1_vld_r && (s1_row_r == row_r);
  assign s1_old  = s1_first_col_r ? '0 : (fwd_r ? fwd_data_r : strip_q_r);
  assign s1_sum  = s1_old + {{(SUM_W-ELEM_W){mat_q_r[ELEM_W-1]}}, mat_q_r};

  always_ff @(posedge clk) begin
    s1_row_r       <= row_r;
    s1_first_col_r <= (right_r == left_r);
    s1_first_row_r <= (row_r == '0);
    s1_last_row_r  <= (DIM_W'(row_r) == rows_m1);
    fwd_r          <= fwd_nxt;
    fwd_data_r     <= s1_sum;
    s2_sum_r       <= s1_sum;
    s2_first_row_r <= s1_first_row_r;
    s2_last_row_r  <= s1_last_row_r;
  end

  assign run_base = s2_first_row_r ? '0 : run_r;
  assign top_base = s2_first_row_r ? MOST_NEG : top_r;
  assign run_sum  = run_base + s2_sum_r;
  assign run_new  = (run_sum < 0) ? '0 : run_sum;
  assign top_new  = (run_new > top_base) ? run_new : top_base;
  assign seen_new = (s2_first_row_r ? 1'b0 : seen_r) | !s2_sum_r[SUM_W-1];
  assign maxv_new = (s2_first_row_r || (s2_sum_r > maxv_r)) ? s2_sum_r : maxv_r;
  // all-negative strip falls back to the largest row sum
  assign strip_res = seen_new ? top_new : maxv_new;

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      run_r  <= run_new;
      top_r  <= top_new;
      maxv_r <= maxv_new;
      seen_r <= seen_new;
    end
    s3_res_r <= strip_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r && s2_last_row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      best_r <= MOST_NEG;
    end else if (s3_vld_r && (s3_res_r > best_r)) begin
      best_r <= s3_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_max_sum_r <= best_r;
    end
  end

endmodule

@@ rtl/msr_checker.sv @@
module msr_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [msr_pkg::SUM_W-1:0]      out_max_sum,
  input logic                                  cfg_psel,
  input logic                                  cfg_penable,
  input logic                                  cfg_pwrite,
  input logic [msr_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input logic [msr_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  input logic [msr_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  input logic                                  cfg_pready
);
  import msr_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_max_sum))
    else $error("stalled result beat changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cfg_psel && cfg_penable && cfg_pwrite)
      && (cfg_paddr[2] == $past(cfg_paddr[2]))
    |-> (cfg_prdata[DIM_W-1:0] == $past(cfg_pwdata[DIM_W-1:0]))
      && (cfg_prdata[CFG_DATA_W-1:DIM_W] == '0))
    else $error("register readback mismatch");

endmodule

bind max_sum_subrectangle_top msr_checker u_msr_checker (.*);

@@ bench/tb_top.sv @@
module tb_top;
  import msr_pkg::*;

  localparam int RUN_LIMIT    = 1_000_000;
  localparam int SETTLE_TICKS = 32;

  typedef enum int {
    FILL_ANY,
    FILL_SMALL,
    FILL_HIGH,
    FILL_LOW,
    FILL_EDGE
  } fill_t;

  // Mirror of the matrix loader and the 2-D max-subrectangle search.
  class subrect_board;
    logic signed [ELEM_W-1:0] cells [STORE_DEPTH];
    longint                   strip_sums [MAX_ROWS];
    logic [POS_W-1:0]         fill_pos;
    logic [DIM_W-1:0]         row_reg;
    logic [DIM_W-1:0]         col_reg;
    logic signed [SUM_W-1:0]  best_sum_q [$];
    int                       errors;

    function new();
      fill_pos = '0;
      row_reg  = DIM_W'(MAX_ROWS);
      col_reg  = DIM_W'(MAX_COLS);
      errors   = 0;
    endfunction

    function int rows_used();
      return (row_reg == 0) ? 1 : ((row_reg > MAX_ROWS) ? MAX_ROWS : int'(row_reg));
    endfunction

    function int cols_used();
      return (col_reg == 0) ? 1 : ((col_reg > MAX_COLS) ? MAX_COLS : int'(col_reg));
    endfunction

    function int position();
      return int'(fill_pos);
    endfunction

    function int pending();
      return best_sum_q.size();
    endfunction

    function void set_dim(logic idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_ROW_COUNT) begin
        row_reg = val[DIM_W-1:0];
      end else begin
        col_reg = val[DIM_W-1:0];
      end
    endfunction

    // 1-D Kadane over the strip; an all-negative strip gives its largest row
    function longint strip_best(int n);
      longint run, top_run, top_one, v;
      bit     any_nonneg;
      run        = 0;
      top_run    = 0;
      top_one    = strip_sums[0];
      any_nonneg = 1'b0;
      for (int i = 0; i < n; i++) begin
        v = strip_sums[ROW_IDX_W'(i)];
        if (v >= 0) any_nonneg = 1'b1;
        if (v > top_one) top_one = v;
        run += v;
        if (run < 0) run = 0;
        if (run > top_run) top_run = run;
      end
      return any_nonneg ? top_run : top_one;
    endfunction

    function logic signed [SUM_W-1:0] predict_best(int rows, int cols);
      longint best, cand;
      best = longint'(MOST_NEG);
      for (int lc = 0; lc < cols; lc++) begin
        foreach (strip_sums[i]) strip_sums[i] = 0;
        for (int rc = lc; rc < cols; rc++) begin
          for (int r = 0; r < rows; r++) begin
            if (r * cols + rc < STORE_DEPTH) begin
              strip_sums[ROW_IDX_W'(r)] += longint'(cells[ADDR_W'(r * cols + rc)]);
            end
          end
          cand = strip_best(rows);
          if (cand > best) best = cand;
        end
      end
      return best[SUM_W-1:0];
    endfunction

    function void take_element(logic signed [ELEM_W-1:0] e);
      int rows, cols;
      rows = rows_used();
      cols = cols_used();
      if (fill_pos < STORE_DEPTH) cells[fill_pos[ADDR_W-1:0]] = e;
      fill_pos++;
      if (fill_pos >= rows * cols) begin
        best_sum_q.push_back(predict_best(rows, cols));
        fill_pos = '0;
      end
    endfunction

    task flag_error(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_sum(logic signed [SUM_W-1:0] got);
      logic signed [SUM_W-1:0] want;
      if (best_sum_q.size() == 0) begin
        flag_error($sformatf("max_sum beat %0d with no matrix pending", got));
      end else begin
        want = best_sum_q.pop_front();
        if (got !== want) flag_error($sformatf("max_sum %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [ELEM_W-1:0]       in_element = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [SUM_W-1:0]        out_max_sum;
  logic                           cfg_psel = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]          cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]          cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]          cfg_prdata;
  logic                           cfg_pready;

  subrect_board board;
  bit           jitter = 1'b1;
  int           hold_cycles = 0;
  int           items_sent = 0;
  int unsigned  cycle_count = 0;

  max_sum_subrectangle_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_element (in_element),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_max_sum(out_max_sum),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_sum(out_max_sum);
  end

  // result side: random stall bursts, plus one long hold on request
  initial begin : result_side
    int gap;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (jitter && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [ELEM_W-1:0] pick_element(fill_t fill);
    logic signed [ELEM_W-1:0] v;
    case (fill)
      FILL_SMALL: v = int'($urandom_range(0, 40)) - 20;
      FILL_HIGH:  v = 32'sh7FFF_FFFF - int'($urandom_range(0, 1000));
      FILL_LOW:   v = 32'sh8000_0000 + int'($urandom_range(0, 1000));
      FILL_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          3:       v = -1;
          default: v = $urandom;
        endcase
      end
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_elem(input logic signed [ELEM_W-1:0] e);
    if (jitter && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_element <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_element(e);
    items_sent++;
  endtask

  // keeps feeding until the current matrix closes
  task automatic finish_matrix(input fill_t fill);
    do begin
      send_elem(pick_element(fill));
    end while (board.position() != 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.set_dim(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols);
    wait_drained();
    cfg_write(REG_ROW_COUNT, rows);
    cfg_write(REG_COL_COUNT, cols);
  endtask

  initial begin : stimulus
    int r, c, nmat, k, kind, total;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default 64x64: one element leaves the load open, then shrink to 1x1 so
    // the position is already past the end and the next element closes it
    send_elem(32'sh7FFF_FFFF);
    set_dims(1, 1);
    send_elem(32'sh1234_5678);
    set_dims(0, 0);
    send_elem(32'sh8000_0000);
    set_dims(2, 3);
    send_elem(-5);
    send_elem(-3);
    // resized mid-load, still short of the new end; all negative
    set_dims(2, 2);
    send_elem(-7);
    send_elem(-2);
    set_dims(3, 2);
    repeat (6) send_elem(32'sh8000_0000);
    set_dims(32'hFFFF_FF82, 32'h0000_0181);
    send_elem(5);
    send_elem(-1);
    set_dims(1, 5);
    send_elem(3);
    send_elem(-4);
    send_elem(5);
    send_elem(-1);
    send_elem(2);
    set_dims(2, 2);
    repeat (4) send_elem(0);

    // long result hold while small matrices keep coming: queue fills up
    set_dims(2, 2);
    hold_cycles = 300;
    repeat (15) finish_matrix(FILL_ANY);
    wait_drained();

    while (items_sent < 800) begin
      jitter = ($urandom_range(0, 4) != 0);
      kind   = $urandom_range(0, 15);
      nmat   = $urandom_range(1, 4);
      if (kind == 0) begin
        r    = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
        c    = $urandom_range(1, 2);
        nmat = 1;
      end else if (kind == 1) begin
        r    = 1;
        c    = $urandom_range(0, 1) ? 64 : $urandom_range(65, 127);
        nmat = 1;
      end else if (kind == 2) begin
        r = 0;
        c = $urandom_range(0, 5);
      end else begin
        r = $urandom_range(1, 6);
        c = $urandom_range(1, 6);
      end
      if ($urandom_range(0, 3) == 0) begin
        set_dims(r | ($urandom & 32'hFFFF_FF80), c | ($urandom & 32'hFFFF_FF80));
      end else begin
        set_dims(r, c);
      end
      repeat (nmat) begin
        total = board.rows_used() * board.cols_used();
        if (total > 1 && $urandom_range(0, 7) == 0) begin
          k = $urandom_range(1, total - 1);
          repeat (k) send_elem(pick_element(FILL_ANY));
          set_dims($urandom_range(1, 6), $urandom_range(1, 6));
        end
        finish_matrix(fill_t'($urandom_range(0, 4)));
      end
    end

    // matrices near the positive limit, no idling from here on
    jitter = 1'b0;
    set_dims(8, 8);
    repeat (3) finish_matrix(FILL_HIGH);
    wait_drained();
    repeat (40) @(posedge clk);

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/msr_pkg.sv
rtl/msr_fifo.sv
rtl/msr_front.sv
rtl/msr_back.sv
rtl/max_sum_subrectangle_top.sv
rtl/msr_checker.sv
bench/tb_top.sv
